// ----- rtl/core/rlba_pkg.sv -----
// package for the rate limited battery averager
// widths, reset values, register indexes and the pipeline load struct
// no dependencies
package rlba_pkg;

	localparam int TIME_W     = 32;
	localparam int ADC_W      = 12;
	localparam int REF_W      = 12;
	localparam int VOLT_W     = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int RING_DEPTH_DEF = 16;

	localparam logic [TIME_W-1:0] START_TICK      = 32'hE000_0000;
	localparam logic [TIME_W-1:0] RESET_INTERVAL  = TIME_W'((30 * 60 * 10) / 3);
	localparam logic [REF_W-1:0]  RESET_REFERENCE = REF_W'(1210);
	localparam logic [ADC_W:0]    ADC_FULL_SCALE  = (ADC_W+1)'(12'hFFF);
	localparam logic [VOLT_W-1:0] VOLT_MAX        = VOLT_W'(16380);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERVAL  = 1'b0,
		CFG_REFERENCE = 1'b1
	} cfg_reg_t;

	// register load strobes, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_ld_t;

endpackage

// ----- rtl/core/rlba_if.sv -----
// channel interfaces for the rate limited battery averager
// depends on rlba_pkg
interface rlba_in_if;
	logic                         valid;
	logic                         ready;
	logic [rlba_pkg::TIME_W-1:0]  now_ms;
	logic [rlba_pkg::ADC_W-1:0]   adc_code;
	modport source (output valid, output now_ms, output adc_code, input ready);
	modport sink (input valid, input now_ms, input adc_code, output ready);
endinterface

interface rlba_out_if;
	logic                         valid;
	logic                         ready;
	logic                         measured;
	logic [rlba_pkg::VOLT_W-1:0]  voltage_mv;
	modport source (output valid, output measured, output voltage_mv, input ready);
	modport sink (input valid, input measured, input voltage_mv, output ready);
endinterface

interface rlba_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rlba_pkg::CFG_IDX_W-1:0]   index;
	logic [rlba_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rlba_scale.sv -----
// adc code to millivolt scaling: multiply by reference, divide by full scale, times four
// two stages; depends on rlba_pkg
module rlba_scale (
	input  logic                          clk,
	input  rlba_pkg::pipe_ld_t            ld,
	input  logic [rlba_pkg::ADC_W-1:0]    adc_code,
	input  logic [rlba_pkg::REF_W-1:0]    reference_mv,
	output logic [rlba_pkg::VOLT_W-1:0]   mv_s2
);
	localparam int PW = rlba_pkg::ADC_W + rlba_pkg::REF_W;
	localparam int QW = PW - rlba_pkg::ADC_W;

	logic [PW-1:0] prod_s1;
	logic [PW:0]   approx;
	logic [QW:0]   q0;
	logic [PW:0]   rem;
	logic [QW:0]   q;

	// divide by 2^n - 1: estimate low by at most one, then correct
	always_comb begin
		approx = {1'b0, prod_s1} + (PW+1)'(prod_s1 >> rlba_pkg::ADC_W);
		q0     = approx[PW -: QW+1];
		rem    = {1'b0, prod_s1} + (PW+1)'(q0) - ((PW+1)'(q0) << rlba_pkg::ADC_W);
		q      = (rem >= (PW+1)'(rlba_pkg::ADC_FULL_SCALE)) ? q0 + 1'b1 : q0;
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			prod_s1 <= PW'(adc_code) * PW'(reference_mv);
		end
		if (ld.s2) begin
			mv_s2 <= {q[QW-1:0], 2'b00};
		end
	end

endmodule

// ----- rtl/core/rlba_ring.sv -----
// sample ring memory with running sum, read at acceptance, written back two stages later
// depends on rlba_pkg
module rlba_ring #(
	parameter int RING_DEPTH = rlba_pkg::RING_DEPTH_DEF,
	parameter int SUM_W      = rlba_pkg::VOLT_W + $clog2(RING_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlba_pkg::pipe_ld_t            ld,
	input  logic                          measure,
	input  logic [rlba_pkg::VOLT_W-1:0]   mv_s2,
	output logic [SUM_W-1:0]              sum
);
	localparam int AW = $clog2(RING_DEPTH);
	localparam int VW = rlba_pkg::VOLT_W;

	logic [VW-1:0] mem [RING_DEPTH];

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic          primed_q;
	logic [VW-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;

	logic          act_s1, prime_s1, oldv_s1;
	logic [AW-1:0] pos_s1;
	logic [VW-1:0] rd_s1;
	logic          act_s2, prime_s2, oldv_s2;
	logic [AW-1:0] pos_s2;
	logic [VW-1:0] rd_s2;

	logic          take;
	logic          we;
	logic [VW-1:0] old;

	assign take = ld.s1 && measure;
	assign we   = ld.s3 && act_s2 && !prime_s2;
	assign old  = oldv_s2 ? rd_s2 : fill_q;
	assign sum  = sum_q;

	// read with bypass of a write to the same entry in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_s2] <= mv_s2;
		end
		if (take) begin
			rd_s1 <= (we && pos_s2 == wp_q) ? mv_s2 : mem[wp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			primed_q  <= 1'b0;
			act_s1    <= 1'b0;
			prime_s1  <= 1'b0;
			oldv_s1   <= 1'b0;
			act_s2    <= 1'b0;
			prime_s2  <= 1'b0;
			oldv_s2   <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (take) begin
				if (!primed_q) begin
					primed_q <= 1'b1;
				end else if (wp_q == AW'(RING_DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (ld.s1) begin
				act_s1   <= measure;
				prime_s1 <= !primed_q;
				oldv_s1  <= wrapped_q;
			end
			if (ld.s2) begin
				act_s2   <= act_s1;
				prime_s2 <= prime_s1;
				oldv_s2  <= oldv_s1;
			end
			if (ld.s3 && act_s2) begin
				if (prime_s2) begin
					sum_q <= SUM_W'(mv_s2) * SUM_W'(RING_DEPTH);
				end else begin
					sum_q <= sum_q - SUM_W'(old) + SUM_W'(mv_s2);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1 <= wp_q;
		end
		if (ld.s2) begin
			pos_s2 <= pos_s1;
			rd_s2  <= rd_s1;
		end
		if (ld.s3 && act_s2 && prime_s2) begin
			fill_q <= mv_s2;
		end
	end

endmodule

// ----- rtl/core/rlba_divn.sv -----
// mean of the ring: running sum divided by the depth via reciprocal multiply and one correction
// depends on rlba_pkg
module rlba_divn #(
	parameter int RING_DEPTH = rlba_pkg::RING_DEPTH_DEF,
	parameter int SUM_W      = rlba_pkg::VOLT_W + $clog2(RING_DEPTH)
) (
	input  logic                          clk,
	input  rlba_pkg::pipe_ld_t            ld,
	input  logic [SUM_W-1:0]              sum,
	output logic [rlba_pkg::VOLT_W-1:0]   mean
);
	localparam int VW      = rlba_pkg::VOLT_W;
	localparam int SH      = SUM_W + 1;
	localparam int RECIP_I = (2 ** SH) / RING_DEPTH;
	localparam logic [SH-1:0] RECIP = SH'(RECIP_I);
	localparam int MW      = SUM_W + SH;

	logic [MW-1:0]    prod;
	logic [VW-1:0]    q0_s4;
	logic [SUM_W-1:0] sum_s4;
	logic [SUM_W:0]   rem;

	assign prod = MW'(sum) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			q0_s4  <= prod[SH +: VW];
			sum_s4 <= sum;
		end
	end

	always_comb begin
		rem  = {1'b0, sum_s4} - (SUM_W+1)'(q0_s4) * (SUM_W+1)'(RING_DEPTH);
		mean = (rem >= (SUM_W+1)'(RING_DEPTH)) ? q0_s4 + 1'b1 : q0_s4;
	end

endmodule

// ----- rtl/core/rate_limited_battery_averager.sv -----
// top level of the rate limited battery averager
// depends on rlba_pkg, rlba_if, rlba_scale, rlba_ring, rlba_divn
//
// One transmit event is taken per clock unless the stages are full behind a waiting result,
// and each gives one result through an elastic five-stage pipeline; new events may enter
// empty stages while a result waits. An event measures when the wrapping millisecond
// difference to the last measured event reaches interval_ms. Samples live in a
// RING_DEPTH-entry memory with a registered read, issued when the event is taken and written
// back two stages later. The first measured event sets the running sum and a fill value, so
// no clearing pass is needed; entries are read from memory only once the ring has wrapped.
module rate_limited_battery_averager #(
	parameter int RING_DEPTH = rlba_pkg::RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rlba_cfg_if.sink    cfg,
	rlba_in_if.sink     evt,
	rlba_out_if.source  res
);
	localparam int VW    = rlba_pkg::VOLT_W;
	localparam int SUM_W = VW + $clog2(RING_DEPTH);

	logic [rlba_pkg::TIME_W-1:0] interval_q;
	logic [rlba_pkg::REF_W-1:0]  reference_q;
	logic [rlba_pkg::TIME_W-1:0] last_tick_q;
	logic [VW-1:0]               last_volt_q;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic meas_s1, meas_s2, meas_s3, meas_s4, out_meas_q;
	logic [VW-1:0] out_volt_q;

	logic free1, free2, free3, free4, free5;
	logic measure;
	rlba_pkg::pipe_ld_t ld;

	logic [VW-1:0]    mv_s2;
	logic [SUM_W-1:0] sum;
	logic [VW-1:0]    mean;
	logic [VW-1:0]    volt_next;

	// elastic stage handshake
	assign free5 = !out_valid_q || res.ready;
	assign free4 = !v_s4 || free5;
	assign free3 = !v_s3 || free4;
	assign free2 = !v_s2 || free3;
	assign free1 = !v_s1 || free2;

	assign ld.s1 = evt.valid && free1;
	assign ld.s2 = v_s1 && free2;
	assign ld.s3 = v_s2 && free3;
	assign ld.s4 = v_s3 && free4;
	assign ld.s5 = v_s4 && free5;

	assign evt.ready = free1;
	assign cfg.ready = 1'b1;

	assign measure   = (evt.now_ms - last_tick_q) >= interval_q;
	assign volt_next = meas_s4 ? mean : last_volt_q;

	assign res.valid      = out_valid_q;
	assign res.measured   = out_meas_q;
	assign res.voltage_mv = out_volt_q;

	rlba_scale u_scale (
		.clk          (clk),
		.ld           (ld),
		.adc_code     (evt.adc_code),
		.reference_mv (reference_q),
		.mv_s2        (mv_s2)
	);

	rlba_ring #(
		.RING_DEPTH (RING_DEPTH),
		.SUM_W      (SUM_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.measure (measure),
		.mv_s2   (mv_s2),
		.sum     (sum)
	);

	rlba_divn #(
		.RING_DEPTH (RING_DEPTH),
		.SUM_W      (SUM_W)
	) u_divn (
		.clk  (clk),
		.ld   (ld),
		.sum  (sum),
		.mean (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= rlba_pkg::RESET_INTERVAL;
			reference_q <= rlba_pkg::RESET_REFERENCE;
			last_tick_q <= rlba_pkg::START_TICK;
			last_volt_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			meas_s1     <= 1'b0;
			meas_s2     <= 1'b0;
			meas_s3     <= 1'b0;
			meas_s4     <= 1'b0;
			out_meas_q  <= 1'b0;
			out_volt_q  <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					rlba_pkg::CFG_INTERVAL:  interval_q  <= cfg.data;
					rlba_pkg::CFG_REFERENCE: reference_q <= cfg.data[rlba_pkg::REF_W-1:0];
					default:                 interval_q  <= interval_q;
				endcase
			end
			if (ld.s1 && measure) begin
				last_tick_q <= evt.now_ms;
			end

			v_s1        <= ld.s1 || (v_s1 && !free2);
			v_s2        <= ld.s2 || (v_s2 && !free3);
			v_s3        <= ld.s3 || (v_s3 && !free4);
			v_s4        <= ld.s4 || (v_s4 && !free5);
			out_valid_q <= ld.s5 || (out_valid_q && !res.ready);

			if (ld.s1) begin
				meas_s1 <= measure;
			end
			if (ld.s2) begin
				meas_s2 <= meas_s1;
			end
			if (ld.s3) begin
				meas_s3 <= meas_s2;
			end
			if (ld.s4) begin
				meas_s4 <= meas_s3;
			end
			if (ld.s5) begin
				out_meas_q  <= meas_s4;
				out_volt_q  <= volt_next;
				last_volt_q <= volt_next;
			end
		end
	end

	// a result always shows the latest reported voltage
	a_result_matches_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.voltage_mv == last_volt_q)
	else $error("result voltage differs from last reported voltage");

	// the mean never leaves the range of a scaled sample
	a_voltage_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.voltage_mv <= rlba_pkg::VOLT_MAX)
	else $error("result voltage out of range");

	// a rejected event leaves the reported voltage unchanged
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ld.s5 && !meas_s4 |=> last_volt_q == $past(last_volt_q))
	else $error("rejected event changed the reported voltage");

endmodule
